// ===== hw/rtl/abts_pkg.sv =====
// Shared types and constants for the array binary tree store.
// Command codes, status codes, controller states and the command/status
// structs between controller and datapath. No dependencies.
`default_nettype none

package abts_pkg;

   // Default geometry of the node table.
   localparam int DEF_NODE_COUNT  = 63;
   localparam int DEF_LEVEL_COUNT = 6;

   // Fixed field widths.
   localparam int CMD_W    = 2;
   localparam int DEPTH_W  = 3;
   localparam int ORDER_W  = 6;
   localparam int LABEL_W  = 8;
   localparam int STATUS_W = 2;
   localparam int LENGTH_W = 6;
   localparam int LEVELS_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR     = 2'd0,
      CMD_ASSIGN    = 2'd1,
      CMD_READ      = 2'd2,
      CMD_RELATIVES = 2'd3
   } cmd_type;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

   // Which table entry the datapath reads this cycle.
   typedef enum logic [2:0] {
      RD_NONE,
      RD_LEFT,
      RD_RIGHT,
      RD_PARENT,
      RD_SIBLING,
      RD_SELF,
      RD_SCAN_UP,
      RD_SCAN_DN
   } rd_sel_type;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_DECODE,
      S_CLEAR,
      S_RD_SELF,
      S_RD_WAIT,
      S_ASG_RL,
      S_ASG_RR,
      S_ASG_RP,
      S_ASG_WAIT,
      S_ASG_WR,
      S_SHR_RD,
      S_SHR_CHK,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_REL_RL,
      S_REL_RR,
      S_REL_RP,
      S_REL_RS,
      S_REL_WAIT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       sweep;
      rd_sel_type rd_sel;
      logic       commit;
      logic       scan_next;
      logic       shrink_step;
      logic       set_len;
      logic       take_hit;
      logic       respond;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    pos_ok;
      logic    key_ok;
      logic    sweep_last;
      logic    ptr_zero;
      logic    ptr_at_len;
      logic    rd_nonzero;
      logic    rd_match;
      logic    shrink_need;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/abts_ctrl.sv =====
// Controller state machine of the array binary tree store.
// Sequences table reads, writes and scans; depends on abts_pkg.
`default_nettype none

module abts_ctrl
   import abts_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire dp_status_type dp_status,
   output logic               busy,
   output dp_cmd_type         dp_cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      dp_cmd.rd_sel = RD_NONE;
      busy     = (state_ff != S_IDLE);
      case (state_ff)
         S_INIT: begin
            dp_cmd.sweep = 1'b1;
            if (dp_status.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               dp_cmd.accept = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            case (dp_status.cmd)
               CMD_CLEAR:     state_in = S_CLEAR;
               CMD_ASSIGN:    state_in = dp_status.pos_ok ? S_ASG_RL : S_RESP;
               CMD_READ:      state_in = dp_status.pos_ok ? S_RD_SELF : S_RESP;
               CMD_RELATIVES: state_in = dp_status.key_ok ? S_SCAN_RD : S_RESP;
               default:       state_in = S_RESP;
            endcase
         end
         S_CLEAR: begin
            dp_cmd.sweep = 1'b1;
            if (dp_status.sweep_last) state_in = S_RESP;
         end
         S_RD_SELF: begin
            dp_cmd.rd_sel = RD_SELF;
            state_in      = S_RD_WAIT;
         end
         S_RD_WAIT: state_in = S_RESP;
         S_ASG_RL: begin
            dp_cmd.rd_sel = RD_LEFT;
            state_in      = S_ASG_RR;
         end
         S_ASG_RR: begin
            dp_cmd.rd_sel = RD_RIGHT;
            state_in      = S_ASG_RP;
         end
         S_ASG_RP: begin
            dp_cmd.rd_sel = RD_PARENT;
            state_in      = S_ASG_WAIT;
         end
         S_ASG_WAIT: state_in = S_ASG_WR;
         S_ASG_WR: begin
            dp_cmd.commit = 1'b1;
            state_in      = dp_status.shrink_need ? S_SHR_RD : S_RESP;
         end
         S_SHR_RD: begin
            if (dp_status.ptr_zero) begin
               dp_cmd.set_len = 1'b1;
               state_in       = S_RESP;
            end else begin
               dp_cmd.rd_sel = RD_SCAN_DN;
               state_in      = S_SHR_CHK;
            end
         end
         S_SHR_CHK: begin
            if (dp_status.rd_nonzero) begin
               dp_cmd.set_len = 1'b1;
               state_in       = S_RESP;
            end else begin
               dp_cmd.shrink_step = 1'b1;
               state_in           = S_SHR_RD;
            end
         end
         S_SCAN_RD: begin
            if (dp_status.ptr_at_len) begin
               state_in = S_RESP;
            end else begin
               dp_cmd.rd_sel = RD_SCAN_UP;
               state_in      = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (dp_status.rd_match) begin
               dp_cmd.take_hit = 1'b1;
               state_in        = S_REL_RL;
            end else begin
               dp_cmd.scan_next = 1'b1;
               state_in         = S_SCAN_RD;
            end
         end
         S_REL_RL: begin
            dp_cmd.rd_sel = RD_LEFT;
            state_in      = S_REL_RR;
         end
         S_REL_RR: begin
            dp_cmd.rd_sel = RD_RIGHT;
            state_in      = S_REL_RP;
         end
         S_REL_RP: begin
            dp_cmd.rd_sel = RD_PARENT;
            state_in      = S_REL_RS;
         end
         S_REL_RS: begin
            dp_cmd.rd_sel = RD_SIBLING;
            state_in      = S_REL_WAIT;
         end
         S_REL_WAIT: state_in = S_RESP;
         S_RESP: begin
            dp_cmd.respond = 1'b1;
            state_in       = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/abts_datapath.sv =====
// Datapath of the array binary tree store: node table memory, index math,
// used-length tracking and result registers. Depends on abts_pkg.
`default_nettype none

module abts_datapath
   import abts_pkg::*;
#(
   parameter int NODE_COUNT  = DEF_NODE_COUNT,
   parameter int LEVEL_COUNT = DEF_LEVEL_COUNT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [CMD_W-1:0]    req_command,
   input  wire logic [DEPTH_W-1:0]  req_position_depth,
   input  wire logic [ORDER_W-1:0]  req_position_order,
   input  wire logic [LABEL_W-1:0]  req_write_value,
   input  wire logic [LABEL_W-1:0]  req_search_key,
   input  wire dp_cmd_type          dp_cmd,
   output dp_status_type            dp_status,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [LABEL_W-1:0]       rsp_read_value,
   output logic                     rsp_key_found,
   output logic [LABEL_W-1:0]       rsp_parent_label,
   output logic [LABEL_W-1:0]       rsp_left_label,
   output logic [LABEL_W-1:0]       rsp_right_label,
   output logic [LABEL_W-1:0]       rsp_left_sibling_label,
   output logic [LABEL_W-1:0]       rsp_right_sibling_label,
   output logic                     rsp_tree_empty,
   output logic [LENGTH_W-1:0]      rsp_used_length,
   output logic [LEVELS_W-1:0]      rsp_tree_levels
);

   localparam int IDX_W  = $clog2(NODE_COUNT);
   localparam int LEN_W  = $clog2(NODE_COUNT + 1);
   localparam int CH_W   = IDX_W + 2;
   localparam int CALC_W = (LEN_W > 8) ? LEN_W : 8;
   localparam int LVC_W  = $clog2(LEN_W + 1);

   // node table
   logic [LABEL_W-1:0] mem [NODE_COUNT];
   logic [LABEL_W-1:0] mem_rd_ff;
   rd_sel_type         cap_sel_ff;
   logic               cap_zero_ff;

   // latched command
   cmd_type            cmd_ff;
   logic [LABEL_W-1:0] wval_ff;
   logic [LABEL_W-1:0] key_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               pos_ok_ff;
   logic               found_ff;
   logic               refused_ff;

   // gathered labels
   logic [LABEL_W-1:0] lab_left_ff;
   logic [LABEL_W-1:0] lab_right_ff;
   logic [LABEL_W-1:0] lab_parent_ff;
   logic [LABEL_W-1:0] lab_sib_ff;
   logic [LABEL_W-1:0] lab_self_ff;

   // tree summary
   logic [LEN_W-1:0]   ptr_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [LABEL_W-1:0] root_ff;

   // result registers
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [LABEL_W-1:0]  rsp_read_value_ff;
   logic                rsp_key_found_ff;
   logic [LABEL_W-1:0]  rsp_parent_label_ff;
   logic [LABEL_W-1:0]  rsp_left_label_ff;
   logic [LABEL_W-1:0]  rsp_right_label_ff;
   logic [LABEL_W-1:0]  rsp_left_sibling_label_ff;
   logic [LABEL_W-1:0]  rsp_right_sibling_label_ff;
   logic                rsp_tree_empty_ff;
   logic [LENGTH_W-1:0] rsp_used_length_ff;
   logic [LEVELS_W-1:0] rsp_tree_levels_ff;

   // position to heap index
   logic [CALC_W-1:0] depth_c;
   logic [CALC_W-1:0] order_c;
   logic [CALC_W-1:0] first_c;
   logic [CALC_W-1:0] idx_c;
   logic              pos_ok_c;

   always_comb begin
      depth_c  = CALC_W'(req_position_depth);
      order_c  = CALC_W'(req_position_order);
      first_c  = CALC_W'(1) << (req_position_depth - DEPTH_W'(1));
      idx_c    = first_c + order_c - CALC_W'(2);
      pos_ok_c = (depth_c >= CALC_W'(1)) && (depth_c <= CALC_W'(LEVEL_COUNT)) &&
                 (order_c >= CALC_W'(1)) && (order_c <= first_c) &&
                 (idx_c < CALC_W'(NODE_COUNT));
   end

   // read address generation; out-of-table reads come back as empty
   logic [CH_W-1:0]  idx_x;
   logic [CH_W-1:0]  ptr_x;
   logic [CH_W-1:0]  left_a;
   logic [CH_W-1:0]  right_a;
   logic [CH_W-1:0]  parent_a;
   logic [CH_W-1:0]  sib_a;
   logic [CH_W-1:0]  rd_full;
   logic             rd_zero;
   logic [IDX_W-1:0] rd_addr;

   always_comb begin
      idx_x    = CH_W'(idx_ff);
      ptr_x    = CH_W'(ptr_ff);
      left_a   = (idx_x << 1) + CH_W'(1);
      right_a  = (idx_x << 1) + CH_W'(2);
      parent_a = (idx_x - CH_W'(1)) >> 1;
      sib_a    = idx_ff[0] ? (idx_x + CH_W'(1)) : (idx_x - CH_W'(1));
      case (dp_cmd.rd_sel)
         RD_LEFT: begin
            rd_full = left_a;
            rd_zero = (left_a >= CH_W'(NODE_COUNT));
         end
         RD_RIGHT: begin
            rd_full = right_a;
            rd_zero = (right_a >= CH_W'(NODE_COUNT));
         end
         RD_PARENT: begin
            rd_full = parent_a;
            rd_zero = (idx_ff == '0);
         end
         RD_SIBLING: begin
            rd_full = sib_a;
            rd_zero = (idx_ff == '0) || (sib_a >= CH_W'(NODE_COUNT));
         end
         RD_SELF: begin
            rd_full = idx_x;
            rd_zero = 1'b0;
         end
         RD_SCAN_UP: begin
            rd_full = ptr_x;
            rd_zero = 1'b0;
         end
         RD_SCAN_DN: begin
            rd_full = ptr_x - CH_W'(1);
            rd_zero = 1'b0;
         end
         default: begin
            rd_full = '0;
            rd_zero = 1'b1;
         end
      endcase
      rd_addr = rd_zero ? '0 : rd_full[IDX_W-1:0];
   end

   logic [LABEL_W-1:0] rd_val;
   assign rd_val = cap_zero_ff ? '0 : mem_rd_ff;

   // tree rules on assign
   logic refuse;
   logic shrink_need;
   assign refuse = ((wval_ff == '0) && ((lab_left_ff != '0) || (lab_right_ff != '0))) ||
                   ((wval_ff != '0) && (idx_ff != '0) && (lab_parent_ff == '0));
   assign shrink_need = !refuse && (wval_ff == '0) &&
                        ((LEN_W'(idx_ff) + LEN_W'(1)) == len_ff);

   always_ff @(posedge clock) begin
      if (dp_cmd.sweep) begin
         mem[ptr_ff[IDX_W-1:0]] <= '0;
      end else if (dp_cmd.commit && !refuse) begin
         mem[idx_ff] <= wval_ff;
      end
      if (dp_cmd.rd_sel != RD_NONE) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         len_ff       <= '0;
         root_ff      <= '0;
         cap_sel_ff   <= RD_NONE;
         cap_zero_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dp_cmd.respond;
         cap_sel_ff   <= dp_cmd.rd_sel;
         cap_zero_ff  <= rd_zero;
         if (dp_cmd.accept) begin
            ptr_ff <= '0;
         end else if (dp_cmd.sweep || dp_cmd.scan_next) begin
            ptr_ff <= ptr_ff + LEN_W'(1);
         end else if (dp_cmd.commit && shrink_need) begin
            ptr_ff <= LEN_W'(idx_ff);
         end else if (dp_cmd.shrink_step) begin
            ptr_ff <= ptr_ff - LEN_W'(1);
         end
         if (dp_cmd.sweep) begin
            len_ff  <= '0;
            root_ff <= '0;
         end else if (dp_cmd.set_len) begin
            len_ff <= ptr_ff;
         end else if (dp_cmd.commit && !refuse) begin
            if (idx_ff == '0) root_ff <= wval_ff;
            if ((wval_ff != '0) && ((LEN_W'(idx_ff) + LEN_W'(1)) > len_ff)) begin
               len_ff <= LEN_W'(idx_ff) + LEN_W'(1);
            end
         end
      end
   end

   // levels: smallest d with 2^d - 1 >= length
   logic [LVC_W-1:0]          lev_c;
   logic [LVC_W+LEVELS_W-1:0] lev_ext;
   logic [LEN_W+LENGTH_W-1:0] len_ext;

   always_comb begin
      lev_c = '0;
      for (int d = 0; d < LEN_W; d++) begin
         if ((LEN_W+1)'((1 << d) - 1) < {1'b0, len_ff}) lev_c = LVC_W'(d + 1);
      end
      lev_ext = {{LEVELS_W{1'b0}}, lev_c};
      len_ext = {{LENGTH_W{1'b0}}, len_ff};
   end

   logic rel_hit;
   assign rel_hit = (cmd_ff == CMD_RELATIVES) && found_ff;

   // payload
   always_ff @(posedge clock) begin
      if (dp_cmd.accept) begin
         cmd_ff     <= cmd_type'(req_command);
         wval_ff    <= req_write_value;
         key_ff     <= req_search_key;
         idx_ff     <= idx_c[IDX_W-1:0];
         pos_ok_ff  <= pos_ok_c;
         found_ff   <= 1'b0;
         refused_ff <= 1'b0;
      end else if (dp_cmd.take_hit) begin
         found_ff <= 1'b1;
         idx_ff   <= ptr_ff[IDX_W-1:0];
      end else if (dp_cmd.commit) begin
         refused_ff <= refuse;
      end

      case (cap_sel_ff)
         RD_LEFT:    lab_left_ff   <= rd_val;
         RD_RIGHT:   lab_right_ff  <= rd_val;
         RD_PARENT:  lab_parent_ff <= rd_val;
         RD_SIBLING: lab_sib_ff    <= rd_val;
         RD_SELF:    lab_self_ff   <= rd_val;
         default: ;
      endcase

      if (dp_cmd.respond) begin
         case (cmd_ff)
            CMD_ASSIGN: rsp_status_ff <= !pos_ok_ff ? ST_OUTSIDE :
                                         (refused_ff ? ST_REFUSED : ST_OK);
            CMD_READ:   rsp_status_ff <= !pos_ok_ff ? ST_OUTSIDE : ST_OK;
            default:    rsp_status_ff <= ST_OK;
         endcase
         rsp_read_value_ff <= ((cmd_ff == CMD_READ) && pos_ok_ff) ? lab_self_ff : '0;
         rsp_key_found_ff    <= rel_hit;
         rsp_parent_label_ff <= rel_hit ? lab_parent_ff : '0;
         rsp_left_label_ff   <= rel_hit ? lab_left_ff : '0;
         rsp_right_label_ff  <= rel_hit ? lab_right_ff : '0;
         rsp_left_sibling_label_ff  <= (rel_hit && !idx_ff[0]) ? lab_sib_ff : '0;
         rsp_right_sibling_label_ff <= (rel_hit && idx_ff[0]) ? lab_sib_ff : '0;
         rsp_tree_empty_ff  <= (root_ff == '0);
         rsp_used_length_ff <= len_ext[LENGTH_W-1:0];
         rsp_tree_levels_ff <= lev_ext[LEVELS_W-1:0];
      end
   end

   always_comb begin
      dp_status.cmd         = cmd_ff;
      dp_status.pos_ok      = pos_ok_ff;
      dp_status.key_ok      = (key_ff != '0) && (root_ff != '0);
      dp_status.sweep_last  = (ptr_ff == LEN_W'(NODE_COUNT - 1));
      dp_status.ptr_zero    = (ptr_ff == '0);
      dp_status.ptr_at_len  = (ptr_ff == len_ff);
      dp_status.rd_nonzero  = (rd_val != '0);
      dp_status.rd_match    = (rd_val == key_ff);
      dp_status.shrink_need = shrink_need;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = rsp_status_ff;
   assign rsp_read_value          = rsp_read_value_ff;
   assign rsp_key_found           = rsp_key_found_ff;
   assign rsp_parent_label        = rsp_parent_label_ff;
   assign rsp_left_label          = rsp_left_label_ff;
   assign rsp_right_label         = rsp_right_label_ff;
   assign rsp_left_sibling_label  = rsp_left_sibling_label_ff;
   assign rsp_right_sibling_label = rsp_right_sibling_label_ff;
   assign rsp_tree_empty          = rsp_tree_empty_ff;
   assign rsp_used_length         = rsp_used_length_ff;
   assign rsp_tree_levels         = rsp_tree_levels_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/array_binary_tree_store.sv =====
// Top level of the array binary tree store; joins abts_ctrl and abts_datapath (abts_pkg).
// Steps on the one read port: read fetches the node; clear sweeps the table; assign reads
// left, right, parent, writes, walks the used length back; relatives scans to the used
// length for the key, then reads its relatives; bad position, zero key, empty tree skip.
// One command at a time; busy drops in the result cycle, so the next start fits there.
// Sync reset clears the table with busy high; results cannot stall.
`default_nettype none

module array_binary_tree_store
   import abts_pkg::*;
#(
   parameter int NODE_COUNT  = DEF_NODE_COUNT,
   parameter int LEVEL_COUNT = DEF_LEVEL_COUNT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // command channel: beat taken when start is high and busy is low
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [CMD_W-1:0]    req_command,
   input  wire logic [DEPTH_W-1:0]  req_position_depth,
   input  wire logic [ORDER_W-1:0]  req_position_order,
   input  wire logic [LABEL_W-1:0]  req_write_value,
   input  wire logic [LABEL_W-1:0]  req_search_key,
   // result channel: one beat per command, valid for a single cycle
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [LABEL_W-1:0]       rsp_read_value,
   output logic                     rsp_key_found,
   output logic [LABEL_W-1:0]       rsp_parent_label,
   output logic [LABEL_W-1:0]       rsp_left_label,
   output logic [LABEL_W-1:0]       rsp_right_label,
   output logic [LABEL_W-1:0]       rsp_left_sibling_label,
   output logic [LABEL_W-1:0]       rsp_right_sibling_label,
   output logic                     rsp_tree_empty,
   output logic [LENGTH_W-1:0]      rsp_used_length,
   output logic [LEVELS_W-1:0]      rsp_tree_levels
);

   // Controller only steers; all storage, index math and the result
   // registers live in the datapath.
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   abts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .busy      (busy),
      .dp_cmd    (dp_cmd)
   );

   // Datapath notes:
   //  - node table is a single-write, single-read memory with registered read data
   //  - child/sibling indexes past the table read as empty
   //  - used length grows on a nonempty write past the end and is walked
   //    back one entry at a time when the last entry is emptied
   //  - key search scans from index 0 up to the used length; first match wins
   abts_datapath #(
      .NODE_COUNT  (NODE_COUNT),
      .LEVEL_COUNT (LEVEL_COUNT)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .req_command             (req_command),
      .req_position_depth      (req_position_depth),
      .req_position_order      (req_position_order),
      .req_write_value         (req_write_value),
      .req_search_key          (req_search_key),
      .dp_cmd                  (dp_cmd),
      .dp_status               (dp_status),
      .rsp_valid               (rsp_valid),
      .rsp_status              (rsp_status),
      .rsp_read_value          (rsp_read_value),
      .rsp_key_found           (rsp_key_found),
      .rsp_parent_label        (rsp_parent_label),
      .rsp_left_label          (rsp_left_label),
      .rsp_right_label         (rsp_right_label),
      .rsp_left_sibling_label  (rsp_left_sibling_label),
      .rsp_right_sibling_label (rsp_right_sibling_label),
      .rsp_tree_empty          (rsp_tree_empty),
      .rsp_used_length         (rsp_used_length),
      .rsp_tree_levels         (rsp_tree_levels)
   );

endmodule

`default_nettype wire
